// ----- rtl/core/mpbm_pkg.sv -----
// Shared types and constants of the multi-pattern byte matcher.
// Used by the controller, the datapath, the top level and the checker.
package mpbm_pkg;

    localparam int MAX_NODES       = 256;
    localparam int NODE_W          = $clog2(MAX_NODES);
    localparam int CNT_W           = NODE_W + 1;
    localparam int GADDR_W         = NODE_W + 8;
    localparam int MAX_PATTERNS    = 64;
    localparam int PAT_W           = 7;
    localparam int PIDX_W          = $clog2(MAX_PATTERNS);
    localparam int MAX_PATTERN_LEN = 16;
    localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
    localparam int POS_W           = 16;
    localparam int MAX_RES         = 16;
    localparam int RES_W           = $clog2(MAX_RES + 1);

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_BUILD   = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    localparam logic [1:0] KIND_MATCH      = 2'd0;
    localparam logic [1:0] KIND_BUILD_DONE = 2'd1;
    localparam logic [1:0] KIND_BUILD_FAIL = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       pattern_end;
    } item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PAT_W-1:0] pattern_id;
        logic [POS_W-1:0] match_start;
        logic [POS_W-1:0] match_end;
        logic             last_result;
    } result_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH,
        ST_LD_RD, ST_LD_CHK, ST_LD_END,
        ST_REPLY,
        ST_BFS_INIT, ST_BFS_POP, ST_BFS_POPW, ST_BFS_RD, ST_BFS_RDW,
        ST_BFS_FWW, ST_BFS_WG, ST_BFS_WGW, ST_BFS_NEXT,
        ST_SC_G, ST_SC_GW, ST_SC_FW, ST_SC_CH, ST_SC_CHW, ST_SC_LW, ST_SC_FIN
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_ACCEPT, OP_DISPATCH,
        OP_LD_RD, OP_LD_CHK, OP_LD_END,
        OP_REPLY,
        OP_BFS_INIT, OP_BFS_POP, OP_BFS_POPW, OP_BFS_RD, OP_BFS_RDW,
        OP_BFS_FWW, OP_BFS_WG, OP_BFS_WGW, OP_BFS_NEXT,
        OP_SC_G, OP_SC_GW, OP_SC_FW, OP_SC_CH, OP_SC_CHW, OP_SC_LW, OP_SC_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       built;
        logic       overflow;
        logic       depth_full;
        logic       pat_end;
        logic       child_zero;
        logic       nodes_full;
        logic       u_root;
        logic       p_root;
        logic       queue_more;
        logic       byte_last;
        logic       id_zero;
        logic       chain_done;
        logic       pend_valid;
        logic       out_free;
        logic [1:0] act;
    } dp_stat_t;

endpackage

// ----- rtl/core/mpbm_ctrl.sv -----
// Sequencer of the matcher: clearing pass, loading, breadth-first build, scan.
// Depends on mpbm_pkg; drives the datapath by command, reads its status.
module mpbm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  mpbm_pkg::dp_stat_t stat,
    output mpbm_pkg::dp_cmd_t  cmd
);
    import mpbm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (stat.clr_done) state_next = ST_IDLE;
            ST_IDLE:     if (item_valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                unique case (stat.act)
                    ACT_LOAD:
                        state_next = (stat.built || stat.overflow || stat.depth_full)
                                     ? ST_IDLE : ST_LD_RD;
                    ACT_BUILD:
                        state_next = (stat.built || stat.overflow) ? ST_REPLY : ST_BFS_INIT;
                    ACT_TEXT:
                        state_next = stat.built ? ST_SC_G : ST_IDLE;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_LD_RD:    state_next = ST_LD_CHK;
            ST_LD_CHK:
            begin
                priority if (stat.child_zero && stat.nodes_full) state_next = ST_IDLE;
                else if (stat.pat_end) state_next = ST_LD_END;
                else state_next = ST_IDLE;
            end
            ST_LD_END:   state_next = ST_IDLE;
            ST_REPLY:    if (stat.out_free) state_next = ST_IDLE;
            ST_BFS_INIT: state_next = ST_BFS_POP;
            ST_BFS_POP:  state_next = stat.queue_more ? ST_BFS_POPW : ST_REPLY;
            ST_BFS_POPW: state_next = ST_BFS_RD;
            ST_BFS_RD:   state_next = ST_BFS_RDW;
            ST_BFS_RDW:
                state_next = (stat.child_zero || stat.u_root) ? ST_BFS_NEXT : ST_BFS_FWW;
            ST_BFS_FWW:  state_next = ST_BFS_WG;
            ST_BFS_WG:   state_next = ST_BFS_WGW;
            ST_BFS_WGW:
                state_next = (!stat.child_zero || stat.p_root) ? ST_BFS_NEXT : ST_BFS_FWW;
            ST_BFS_NEXT: state_next = stat.byte_last ? ST_BFS_POP : ST_BFS_RD;
            ST_SC_G:     state_next = ST_SC_GW;
            ST_SC_GW:
                state_next = (!stat.child_zero || stat.p_root) ? ST_SC_CH : ST_SC_FW;
            ST_SC_FW:    state_next = ST_SC_G;
            ST_SC_CH:    state_next = stat.chain_done ? ST_SC_FIN : ST_SC_CHW;
            ST_SC_CHW:   state_next = stat.id_zero ? ST_SC_CH : ST_SC_LW;
            ST_SC_LW:    if (!stat.pend_valid || stat.out_free) state_next = ST_SC_CH;
            ST_SC_FIN:   if (!stat.pend_valid || stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:    cmd.op = OP_CLEAR;
            ST_IDLE:     cmd.op = item_valid ? OP_ACCEPT : OP_NONE;
            ST_DISPATCH: cmd.op = OP_DISPATCH;
            ST_LD_RD:    cmd.op = OP_LD_RD;
            ST_LD_CHK:   cmd.op = OP_LD_CHK;
            ST_LD_END:   cmd.op = OP_LD_END;
            ST_REPLY:    cmd.op = OP_REPLY;
            ST_BFS_INIT: cmd.op = OP_BFS_INIT;
            ST_BFS_POP:  cmd.op = OP_BFS_POP;
            ST_BFS_POPW: cmd.op = OP_BFS_POPW;
            ST_BFS_RD:   cmd.op = OP_BFS_RD;
            ST_BFS_RDW:  cmd.op = OP_BFS_RDW;
            ST_BFS_FWW:  cmd.op = OP_BFS_FWW;
            ST_BFS_WG:   cmd.op = OP_BFS_WG;
            ST_BFS_WGW:  cmd.op = OP_BFS_WGW;
            ST_BFS_NEXT: cmd.op = OP_BFS_NEXT;
            ST_SC_G:     cmd.op = OP_SC_G;
            ST_SC_GW:    cmd.op = OP_SC_GW;
            ST_SC_FW:    cmd.op = OP_SC_FW;
            ST_SC_CH:    cmd.op = OP_SC_CH;
            ST_SC_CHW:   cmd.op = OP_SC_CHW;
            ST_SC_LW:    cmd.op = OP_SC_LW;
            ST_SC_FIN:   cmd.op = OP_SC_FIN;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/core/mpbm_dp.sv -----
// Datapath of the matcher: goto, failure, pattern and queue memories, cursors,
// counters and the output register. Depends on mpbm_pkg; run by mpbm_ctrl.
module mpbm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  mpbm_pkg::item_t    item,
    input  mpbm_pkg::dp_cmd_t  cmd,
    output mpbm_pkg::dp_stat_t stat,
    output logic               result_valid,
    input  logic               result_stall,
    output mpbm_pkg::result_t  result
);
    import mpbm_pkg::*;

    localparam int GDEPTH = MAX_NODES * 256;

    // memories
    logic [NODE_W-1:0] goto_mem  [GDEPTH];
    logic [NODE_W-1:0] fail_mem  [MAX_NODES];
    logic [PAT_W-1:0]  npat_mem  [MAX_NODES];
    logic [LEN_W-1:0]  plen_mem  [MAX_PATTERNS];
    logic [NODE_W-1:0] queue_mem [MAX_NODES];

    logic               g_we, g_re, f_we, f_re, n_we, n_re, l_we, l_re, q_we, q_re;
    logic [GADDR_W-1:0] g_waddr, g_raddr;
    logic [NODE_W-1:0]  g_wdata, f_waddr, f_raddr, f_wdata, n_waddr, n_raddr;
    logic [NODE_W-1:0]  q_waddr, q_raddr, q_wdata;
    logic [PAT_W-1:0]   n_wdata;
    logic [PIDX_W-1:0]  l_waddr, l_raddr;
    logic [LEN_W-1:0]   l_wdata;
    logic [NODE_W-1:0]  g_rdata_reg, f_rdata_reg, q_rdata_reg;
    logic [PAT_W-1:0]   n_rdata_reg;
    logic [LEN_W-1:0]   l_rdata_reg;

    // control state
    logic [GADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]  cursor_reg, cursor_next;
    logic [LEN_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]   node_cnt_reg, node_cnt_next;
    logic [PAT_W-1:0]   pat_cnt_reg, pat_cnt_next;
    logic [NODE_W-1:0]  search_reg, search_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ovf_reg, ovf_next;
    logic               built_reg, built_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               res_valid_reg, res_valid_next;

    // working registers
    logic [1:0]         act_reg, act_next;
    logic [7:0]         byte_reg, byte_next;
    logic               end_reg, end_next;
    logic [NODE_W-1:0]  u_reg, u_next, p_reg, p_next, c_reg, c_next, pn_reg, pn_next;
    logic [7:0]         b_reg, b_next;
    logic [CNT_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [PAT_W-1:0]   id_reg, id_next;
    logic [RES_W-1:0]   n_reg, n_next;
    result_t            pend_reg, pend_next, res_reg, res_next;

    logic               child_zero, depth_full, nodes_full, pats_full, out_free, can_enq;
    logic [NODE_W-1:0]  c_new;
    logic [PAT_W-1:0]   id_m1;
    result_t            new_match;

    assign child_zero = (g_rdata_reg == '0);
    assign depth_full = (depth_reg >= LEN_W'(MAX_PATTERN_LEN));
    assign nodes_full = (node_cnt_reg >= CNT_W'(MAX_NODES));
    assign pats_full  = (pat_cnt_reg >= PAT_W'(MAX_PATTERNS));
    assign out_free   = !res_valid_reg || !result_stall;
    assign can_enq    = (tail_reg < CNT_W'(MAX_NODES));
    assign c_new      = child_zero ? node_cnt_reg[NODE_W-1:0] : g_rdata_reg;
    assign id_m1      = n_rdata_reg - PAT_W'(1);

    always_comb
    begin
        new_match             = '0;
        new_match.kind        = KIND_MATCH;
        new_match.pattern_id  = id_reg;
        new_match.match_end   = pos_reg;
        new_match.match_start = pos_reg - POS_W'(l_rdata_reg) + POS_W'(1);
    end

    always_comb
    begin
        stat.clr_done   = (clr_cnt_reg == GADDR_W'(GDEPTH - 1));
        stat.built      = built_reg;
        stat.overflow   = ovf_reg;
        stat.depth_full = depth_full;
        stat.pat_end    = end_reg;
        stat.child_zero = child_zero;
        stat.nodes_full = nodes_full;
        stat.u_root     = (u_reg == '0);
        stat.p_root     = (p_reg == '0);
        stat.queue_more = (head_reg < tail_reg) && (head_reg < CNT_W'(MAX_NODES));
        stat.byte_last  = (b_reg == 8'hFF);
        stat.id_zero    = (n_rdata_reg == '0);
        stat.chain_done = (p_reg == '0) || (n_reg == RES_W'(MAX_RES));
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
        stat.act        = act_reg;
    end

    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        cursor_next     = cursor_reg;
        depth_next      = depth_reg;
        node_cnt_next   = node_cnt_reg;
        pat_cnt_next    = pat_cnt_reg;
        search_next     = search_reg;
        pos_next        = pos_reg;
        ovf_next        = ovf_reg;
        built_next      = built_reg;
        pend_valid_next = pend_valid_reg;
        act_next        = act_reg;
        byte_next       = byte_reg;
        end_next        = end_reg;
        u_next          = u_reg;
        p_next          = p_reg;
        c_next          = c_reg;
        pn_next         = pn_reg;
        b_next          = b_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        id_next         = id_reg;
        n_next          = n_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        res_valid_next  = out_free ? 1'b0 : res_valid_reg;
        g_we = 1'b0; g_re = 1'b0; f_we = 1'b0; f_re = 1'b0; n_we = 1'b0;
        n_re = 1'b0; l_we = 1'b0; l_re = 1'b0; q_we = 1'b0; q_re = 1'b0;
        g_waddr = '0; g_raddr = '0; g_wdata = '0;
        f_waddr = '0; f_raddr = '0; f_wdata = '0;
        n_waddr = '0; n_raddr = '0; n_wdata = '0;
        l_waddr = '0; l_raddr = '0; l_wdata = '0;
        q_waddr = '0; q_raddr = '0; q_wdata = '0;

        unique case (cmd.op)
            OP_CLEAR:
            begin
                g_we         = 1'b1;
                g_waddr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + GADDR_W'(1);
            end
            OP_ACCEPT:
            begin
                act_next  = item.action;
                byte_next = item.data_byte;
                end_next  = item.pattern_end;
            end
            OP_DISPATCH:
            begin
                p_next = search_reg;
                unique case (act_reg)
                    ACT_LOAD:
                    begin
                        if (!built_reg)
                        begin
                            if (!ovf_reg && depth_full)
                                ovf_next = 1'b1;
                            if ((ovf_reg || depth_full) && end_reg)
                            begin
                                cursor_next = '0;
                                depth_next  = '0;
                            end
                        end
                    end
                    ACT_BUILD:
                    begin
                        cursor_next = '0;
                        depth_next  = '0;
                    end
                    ACT_RESTART:
                    begin
                        search_next = '0;
                        pos_next    = '0;
                    end
                    default: ;
                endcase
            end
            OP_LD_RD:
            begin
                g_re    = 1'b1;
                g_raddr = {cursor_reg, byte_reg};
            end
            OP_LD_CHK:
            begin
                if (child_zero && nodes_full)
                begin
                    ovf_next = 1'b1;
                    if (end_reg)
                    begin
                        cursor_next = '0;
                        depth_next  = '0;
                    end
                end
                else
                begin
                    if (child_zero)
                    begin
                        // allocate a fresh node under the cursor
                        g_we          = 1'b1;
                        g_waddr       = {cursor_reg, byte_reg};
                        g_wdata       = c_new;
                        f_we          = 1'b1;
                        f_waddr       = c_new;
                        n_we          = 1'b1;
                        n_waddr       = c_new;
                        node_cnt_next = node_cnt_reg + CNT_W'(1);
                    end
                    cursor_next = c_new;
                    depth_next  = depth_reg + LEN_W'(1);
                    c_next      = c_new;
                end
            end
            OP_LD_END:
            begin
                if (pats_full)
                    ovf_next = 1'b1;
                else
                begin
                    pat_cnt_next = pat_cnt_reg + PAT_W'(1);
                    n_we         = 1'b1;
                    n_waddr      = c_reg;
                    n_wdata      = pat_cnt_reg + PAT_W'(1);
                    l_we         = 1'b1;
                    l_waddr      = pat_cnt_reg[PIDX_W-1:0];
                    l_wdata      = depth_reg;
                end
                cursor_next = '0;
                depth_next  = '0;
            end
            OP_REPLY:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.kind        = built_reg ? KIND_BUILD_DONE : KIND_BUILD_FAIL;
                    res_next.last_result = 1'b1;
                end
            end
            OP_BFS_INIT:
            begin
                q_we      = 1'b1;
                head_next = '0;
                tail_next = CNT_W'(1);
            end
            OP_BFS_POP:
            begin
                if (stat.queue_more)
                begin
                    q_re      = 1'b1;
                    q_raddr   = head_reg[NODE_W-1:0];
                    head_next = head_reg + CNT_W'(1);
                end
                else
                begin
                    built_next  = 1'b1;
                    search_next = '0;
                end
            end
            OP_BFS_POPW:
            begin
                u_next = q_rdata_reg;
                b_next = '0;
            end
            OP_BFS_RD:
            begin
                g_re    = 1'b1;
                g_raddr = {u_reg, b_reg};
            end
            OP_BFS_RDW:
            begin
                c_next = g_rdata_reg;
                if (!child_zero)
                begin
                    if (u_reg == '0)
                    begin
                        f_we    = 1'b1;
                        f_waddr = g_rdata_reg;
                        if (can_enq)
                        begin
                            q_we      = 1'b1;
                            q_waddr   = tail_reg[NODE_W-1:0];
                            q_wdata   = g_rdata_reg;
                            tail_next = tail_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        f_re    = 1'b1;
                        f_raddr = u_reg;
                    end
                end
            end
            OP_BFS_FWW: p_next = f_rdata_reg;
            OP_BFS_WG:
            begin
                g_re    = 1'b1;
                g_raddr = {p_reg, b_reg};
            end
            OP_BFS_WGW:
            begin
                if (!child_zero || (p_reg == '0))
                begin
                    // child found, or root reached: either way the link is the read value
                    f_we    = 1'b1;
                    f_waddr = c_reg;
                    f_wdata = g_rdata_reg;
                    if (can_enq)
                    begin
                        q_we      = 1'b1;
                        q_waddr   = tail_reg[NODE_W-1:0];
                        q_wdata   = c_reg;
                        tail_next = tail_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    f_re    = 1'b1;
                    f_raddr = p_reg;
                end
            end
            OP_BFS_NEXT: b_next = b_reg + 8'd1;
            OP_SC_G:
            begin
                g_re    = 1'b1;
                g_raddr = {p_reg, byte_reg};
            end
            OP_SC_GW:
            begin
                if (!child_zero || (p_reg == '0))
                begin
                    search_next = g_rdata_reg;
                    p_next      = g_rdata_reg;
                    n_next      = '0;
                end
                else
                begin
                    f_re    = 1'b1;
                    f_raddr = p_reg;
                end
            end
            OP_SC_FW: p_next = f_rdata_reg;
            OP_SC_CH:
            begin
                if (!stat.chain_done)
                begin
                    n_re    = 1'b1;
                    n_raddr = p_reg;
                    f_re    = 1'b1;
                    f_raddr = p_reg;
                end
            end
            OP_SC_CHW:
            begin
                id_next = n_rdata_reg;
                pn_next = f_rdata_reg;
                if (n_rdata_reg != '0)
                begin
                    l_re    = 1'b1;
                    l_raddr = id_m1[PIDX_W-1:0];
                end
                else
                    p_next = f_rdata_reg;
            end
            OP_SC_LW:
            begin
                // hold the newest match back until we know whether it is the last
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = pend_reg;
                    end
                    pend_next       = new_match;
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + RES_W'(1);
                    p_next          = pn_reg;
                end
            end
            OP_SC_FIN:
            begin
                if (!pend_valid_reg)
                    pos_next = pos_reg + POS_W'(1);
                else if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = pend_reg;
                    res_next.last_result = 1'b1;
                    pend_valid_next      = 1'b0;
                    pos_next             = pos_reg + POS_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            cursor_reg     <= '0;
            depth_reg      <= '0;
            node_cnt_reg   <= CNT_W'(1);
            pat_cnt_reg    <= '0;
            search_reg     <= '0;
            pos_reg        <= '0;
            ovf_reg        <= 1'b0;
            built_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            cursor_reg     <= cursor_next;
            depth_reg      <= depth_next;
            node_cnt_reg   <= node_cnt_next;
            pat_cnt_reg    <= pat_cnt_next;
            search_reg     <= search_next;
            pos_reg        <= pos_next;
            ovf_reg        <= ovf_next;
            built_reg      <= built_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
        u_reg    <= u_next;
        p_reg    <= p_next;
        c_reg    <= c_next;
        pn_reg   <= pn_next;
        b_reg    <= b_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        id_reg   <= id_next;
        n_reg    <= n_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (g_we) goto_mem[g_waddr] <= g_wdata;
        if (g_re) g_rdata_reg <= goto_mem[g_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we) fail_mem[f_waddr] <= f_wdata;
        if (f_re) f_rdata_reg <= fail_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (n_we) npat_mem[n_waddr] <= n_wdata;
        if (n_re) n_rdata_reg <= npat_mem[n_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we) plen_mem[l_waddr] <= l_wdata;
        if (l_re) l_rdata_reg <= plen_mem[l_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we) queue_mem[q_waddr] <= q_wdata;
        if (q_re) q_rdata_reg <= queue_mem[q_raddr];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- rtl/core/multi_pattern_byte_matcher.sv -----
// Multi-pattern byte matcher (trie with failure links); top level over mpbm_ctrl/mpbm_dp.
// Each accepted beat is handled in full before the next is taken, item_stall staying high.
// A text byte follows failure links until a child is found, then walks the output chain,
// reporting each node that ends a pattern. A build fills the failure links breadth-first.
// Reset: asynchronous; a clearing pass then empties the goto memory while item_stall
// stays high. Results leave through a registered beat.
module multi_pattern_byte_matcher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mpbm_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mpbm_pkg::result_t result
);
    import mpbm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mpbm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    mpbm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- rtl/core/mpbm_chk.sv -----
// Port-level checks of the matcher's result channel, bound to the top level.
// Depends on mpbm_pkg.
module mpbm_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input mpbm_pkg::result_t result
);
    import mpbm_pkg::*;

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kind == KIND_MATCH || result.kind == KIND_BUILD_DONE
                          || result.kind == KIND_BUILD_FAIL))
        else $error("reserved result kind");

    a_build: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_MATCH
        |-> result.last_result && result.pattern_id == '0)
        else $error("build reply malformed");

    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_MATCH |-> result.pattern_id != '0)
        else $error("match without pattern number");

endmodule

bind multi_pattern_byte_matcher mpbm_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
